FILE: hw/rtl/llwp_pkg.sv
`default_nettype none

package llwp_pkg;

  localparam int LANES_DEFAULT = 8;
  localparam int LEVEL_W       = 6;
  localparam int BRIGHT_W      = 8;
  localparam int LANE_W        = 3;
  localparam int PADDR_W       = 4;
  localparam int PDATA_W       = 32;

  localparam logic [LEVEL_W-1:0] END_LEVEL_RST   = 6'd60;
  localparam logic [LEVEL_W-1:0] START_LEVEL_RST = 6'd10;
  localparam logic [LEVEL_W-1:0] PROP_LEVEL_RST  = 6'd30;
  localparam logic               UP_DIR_RST      = 1'b0;

  typedef enum logic [1:0] {
    REG_END_LEVEL   = 2'd0,
    REG_START_LEVEL = 2'd1,
    REG_PROP_LEVEL  = 2'd2,
    REG_UP_DIR      = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] end_level;
    logic [LEVEL_W-1:0] start_level;
    logic [LEVEL_W-1:0] propagate_level;
    logic               up_direction;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic idx_last;
  } status_t;

  localparam logic [BRIGHT_W-1:0] GAMMA_LUT [0:63] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h08, 8'h09, 8'h0b, 8'h0d, 8'h0f, 8'h11, 8'h13, 8'h16,
    8'h1a, 8'h1c, 8'h1d, 8'h1f, 8'h22, 8'h25, 8'h28, 8'h2e,
    8'h34, 8'h38, 8'h3c, 8'h40, 8'h44, 8'h48, 8'h4b, 8'h4f,
    8'h55, 8'h5a, 8'h5f, 8'h64, 8'h69, 8'h6d, 8'h72, 8'h77,
    8'h7d, 8'h80, 8'h88, 8'h8d, 8'h94, 8'h9a, 8'ha0, 8'ha7,
    8'hac, 8'hb0, 8'hb9, 8'hbf, 8'hc6, 8'hcb, 8'hcf, 8'hd6,
    8'he1, 8'he9, 8'hed, 8'hf1, 8'hf6, 8'hfa, 8'hfe, 8'hff
  };

  function automatic logic [LEVEL_W-1:0] step_toward(input logic [LEVEL_W-1:0] v,
                                                     input logic [LEVEL_W-1:0] target);
    logic [LEVEL_W-1:0] r;
    if (v < target) begin
      r = v + 1'b1;
    end else if (v > target) begin
      r = v - 1'b1;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/led_lane_wave_pattern.sv
// Lane wave pattern generator.
// Tick channel: tick_valid / tick_stall with a restart flag. One accepted tick
// updates every lane level and produces LANES result items (lane, brightness,
// last) on the result channel, in lane order, last set on the top lane.
// Lanes are handled one per cycle by a single shared update unit while the
// output register can take a result: first the tick is taken, then the lanes
// are updated in order, each into the output register. tick_stall stays high
// until the top lane has been computed; the next tick can then be taken while
// the last result still waits in the output register.
// A stalled receiver holds the output register and freezes lane processing;
// no item is dropped.
// Registers on the APB port (byte address 4*i): end_level, start_level,
// propagate_level, up_direction. Write them only while the block is idle.
// Synchronous reset clears all lane levels, rising flags and the lead lane,
// loads the register defaults (60, 10, 30, 0) and empties the output.
`default_nettype none

module led_lane_wave_pattern #(
  parameter int LANES = llwp_pkg::LANES_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           tick_valid,
  output logic                                tick_stall,
  input  wire logic                           restart,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic      [llwp_pkg::LANE_W-1:0]    lane,
  output logic      [llwp_pkg::BRIGHT_W-1:0]  brightness,
  output logic                                last,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [llwp_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [llwp_pkg::PDATA_W-1:0]   pwdata,
  output logic      [llwp_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready
);
  import llwp_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  llwp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  llwp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .status     (status),
    .cmd        (cmd)
  );

  llwp_datapath #(
    .LANES (LANES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .lane         (lane),
    .brightness   (brightness),
    .last         (last)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/llwp_regs.sv
`default_nettype none

module llwp_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [llwp_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [llwp_pkg::PDATA_W-1:0]  pwdata,
  output logic      [llwp_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output llwp_pkg::cfg_t                     cfg
);
  import llwp_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.end_level       <= END_LEVEL_RST;
      cfg.start_level     <= START_LEVEL_RST;
      cfg.propagate_level <= PROP_LEVEL_RST;
      cfg.up_direction    <= UP_DIR_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_END_LEVEL:   cfg.end_level       <= pwdata[LEVEL_W-1:0];
        REG_START_LEVEL: cfg.start_level     <= pwdata[LEVEL_W-1:0];
        REG_PROP_LEVEL:  cfg.propagate_level <= pwdata[LEVEL_W-1:0];
        REG_UP_DIR:      cfg.up_direction    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_END_LEVEL:   prdata = PDATA_W'(cfg.end_level);
      REG_START_LEVEL: prdata = PDATA_W'(cfg.start_level);
      REG_PROP_LEVEL:  prdata = PDATA_W'(cfg.propagate_level);
      REG_UP_DIR:      prdata = PDATA_W'(cfg.up_direction);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/llwp_ctrl.sv
`default_nettype none

module llwp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              tick_valid,
  output logic                   tick_stall,
  input  wire llwp_pkg::status_t status,
  output llwp_pkg::cmd_t         cmd
);
  import llwp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    tick_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        tick_stall = 1'b0;
        if (tick_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        // one lane per cycle while the output register can take it
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.idx_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/llwp_datapath.sv
`default_nettype none

module llwp_datapath #(
  parameter int LANES = llwp_pkg::LANES_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           restart,
  input  wire llwp_pkg::cfg_t                 cfg,
  input  wire llwp_pkg::cmd_t                 cmd,
  output llwp_pkg::status_t                   status,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic      [llwp_pkg::LANE_W-1:0]    lane,
  output logic      [llwp_pkg::BRIGHT_W-1:0]  brightness,
  output logic                                last
);
  import llwp_pkg::*;

  localparam int IW = $clog2(LANES);
  localparam logic [IW-1:0] TOP_LANE = IW'(LANES - 1);

  logic [LEVEL_W-1:0] levels [LANES];
  logic [LANES-1:0]   rising;
  logic [IW-1:0]      lead;
  logic [IW-1:0]      idx;
  logic               restart_q;
  logic               lead_hit;

  logic [LEVEL_W-1:0] cur_lvl;
  logic [LEVEL_W-1:0] new_lvl;
  logic               new_rise;
  logic               at_lead;
  logic               hit_now;
  logic               idx_last;
  logic               taken;

  assign cur_lvl  = levels[idx];
  assign at_lead  = (idx == lead);
  assign idx_last = (idx == TOP_LANE);
  assign taken    = result_valid & ~result_stall;

  assign status.out_free = ~result_valid | ~result_stall;
  assign status.idx_last = idx_last;

  always_comb begin
    new_lvl  = cur_lvl;
    new_rise = rising[idx];
    if (restart_q) begin
      new_lvl = cfg.start_level;
    end else if (rising[idx] | at_lead) begin
      if (cur_lvl != cfg.end_level) begin
        new_lvl  = step_toward(cur_lvl, cfg.end_level);
        new_rise = 1'b1;
      end else begin
        new_rise = 1'b0;
      end
    end else begin
      new_lvl = step_toward(cur_lvl, cfg.start_level);
    end
  end

  assign hit_now = at_lead & (new_lvl == cfg.propagate_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        levels[i] <= '0;
      end
      rising   <= '0;
      lead     <= '0;
      idx      <= '0;
      lead_hit <= 1'b0;
      restart_q <= 1'b0;
    end else if (cmd.load) begin
      restart_q <= restart;
      idx       <= '0;
      lead_hit  <= 1'b0;
    end else if (cmd.step) begin
      levels[idx] <= new_lvl;
      rising[idx] <= new_rise;
      idx         <= idx + 1'b1;
      if (hit_now) begin
        lead_hit <= 1'b1;
      end
      if (idx_last) begin
        if (restart_q) begin
          lead <= cfg.up_direction ? TOP_LANE : '0;
        end else if (lead_hit | hit_now) begin
          if (cfg.up_direction) begin
            lead <= (lead == TOP_LANE) ? '0 : lead + 1'b1;
          end else begin
            lead <= (lead == '0) ? TOP_LANE : lead - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.step) begin
      result_valid <= 1'b1;
    end else if (taken) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      lane       <= LANE_W'(idx);
      brightness <= GAMMA_LUT[new_lvl];
      last       <= idx_last;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/llwp_checker.sv
`default_nettype none

module llwp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          tick_valid,
  input wire logic                          tick_stall,
  input wire logic                          result_valid,
  input wire logic                          result_stall,
  input wire logic [llwp_pkg::LANE_W-1:0]   lane,
  input wire logic [llwp_pkg::BRIGHT_W-1:0] brightness,
  input wire logic                          last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(lane)
      && $stable(brightness) && $stable(last))
    else $error("stalled result changed");

  a_busy_after_tick: assert property (@(posedge clk) disable iff (rst)
    tick_valid && !tick_stall |=> tick_stall)
    else $error("tick taken while previous tick still open");

  a_more_lanes: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !last |=> result_valid)
    else $error("gap between lanes of one tick");

  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    !tick_stall && result_valid |-> last)
    else $error("idle while a non-final result waits");

endmodule

bind led_lane_wave_pattern llwp_checker u_llwp_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick_valid),
  .tick_stall   (tick_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .lane         (lane),
  .brightness   (brightness),
  .last         (last)
);

`default_nettype wire
